FILE: sv/wsd_pkg.sv
package wsd_pkg;

   // parse phase codes
   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_MASK    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;

   // frame status codes
   localparam logic [1:0] ST_BINARY  = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_CLOSE   = 2'd2;
   localparam logic [1:0] ST_REJECT  = 2'd3;

   // opcodes
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;

   // 7-bit length escapes
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // last byte index of the extended lengths and the mask key
   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] MASK_LAST  = 3'd3;

   typedef struct packed {
      logic       emit;
      logic       has_byte;
      logic [7:0] payload_byte;
      logic       frame_end;
      logic [1:0] frame_status;
   } result_type;

   function automatic logic [1:0] status_of(input logic [3:0] op);
      logic [1:0] st;
      case (op)
         OP_BINARY:         st = ST_BINARY;
         OP_TEXT, OP_PING:  st = ST_IGNORED;
         OP_CLOSE:          st = ST_CLOSE;
         default:           st = ST_REJECT;
      endcase
      return st;
   endfunction

endpackage

FILE: sv/wsd_ifs.sv
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] payload_byte;
   logic       frame_end;
   logic [1:0] frame_status;

   modport source (output valid, output has_byte, output payload_byte,
                   output frame_end, output frame_status, input ready);
   modport sink   (input valid, input has_byte, input payload_byte,
                   input frame_end, input frame_status, output ready);
endinterface

FILE: sv/websocket_frame_deframer_top.sv
// websocket frame deframer
// req_chan carries the framed byte stream, one byte per item. rsp_chan
// carries at most one item per input byte: a binary-frame payload byte
// (has_byte, unmasked), and/or the end of a frame (frame_end with
// frame_status: binary, ignored ping/text, close, rejected opcode).
// header bytes and payload of non-binary frames give no item, except the
// byte that finishes a frame.
// a result is registered: it is on rsp_chan in the cycle after its byte is accepted.
// throughput: one byte per cycle while the receiver keeps up; the parser state updates in the same
// cycle the byte is taken, and a single output register holds the result.
// req_chan.ready stays high while the output register is empty or being
// drained, so a byte may be taken while a result is delivered.
// when the receiver stalls with a result pending, req_chan.ready drops and
// the pending result holds until rsp_chan.ready is seen.
// reset (synchronous, active high) returns the parser to expecting the
// first header byte and empties the output register; req_chan.ready is
// held low while reset is high.
module websocket_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_chan,
   wsd_rsp_if.source  rsp_chan
);

   wsd_pkg::result_type step;
   logic                take;

   logic       rsp_valid_ff;
   logic       has_byte_ff;
   logic [7:0] payload_byte_ff;
   logic       frame_end_ff;
   logic [1:0] frame_status_ff;

   // take a byte when the output slot is free or emptying this cycle
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign take           = req_chan.valid && req_chan.ready;

   // header walk, length count, unmask
   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .stream_byte (req_chan.stream_byte),
      .result      (step)
   );

   // output register: valid is control, payload loads only on a new result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= step.emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && step.emit) begin
         has_byte_ff     <= step.has_byte;
         payload_byte_ff <= step.payload_byte;
         frame_end_ff    <= step.frame_end;
         frame_status_ff <= step.frame_status;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.has_byte     = has_byte_ff;
   assign rsp_chan.payload_byte = payload_byte_ff;
   assign rsp_chan.frame_end    = frame_end_ff;
   assign rsp_chan.frame_status = frame_status_ff;

endmodule

FILE: sv/wsd_parser.sv
module wsd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           stream_byte,
   output wsd_pkg::result_type  result
);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [2:0]  hcount_ff, hcount_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  pos_ff, pos_in;

   logic        finish_len;
   logic        finish_hdr;
   logic [7:0]  key_byte;
   logic [63:0] rem_dec;
   logic        last;

   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      mask_in      = mask_ff;
      remaining_in = remaining_ff;
      hcount_in    = hcount_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      finish_len   = 1'b0;
      finish_hdr   = 1'b0;
      result       = '0;
      rem_dec      = remaining_ff - 64'd1;
      last         = (rem_dec == 64'd0);

      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (!mask_ff) begin
         key_byte = 8'd0;
      end

      unique case (phase_ff)
         wsd_pkg::PH_HDR1: begin
            mask_in      = stream_byte[7];
            hcount_in    = 3'd0;
            remaining_in = 64'd0;
            if (stream_byte[6:0] == wsd_pkg::LEN_EXT16) begin
               phase_in = wsd_pkg::PH_EXT16;
            end else if (stream_byte[6:0] == wsd_pkg::LEN_EXT64) begin
               phase_in = wsd_pkg::PH_EXT64;
            end else begin
               remaining_in = {57'd0, stream_byte[6:0]};
               finish_len   = 1'b1;
            end
         end
         wsd_pkg::PH_EXT16: begin
            remaining_in = {48'd0, remaining_ff[7:0], stream_byte};
            if (hcount_ff >= wsd_pkg::EXT16_LAST) begin
               finish_len = 1'b1;
            end else begin
               hcount_in = hcount_ff + 3'd1;
            end
         end
         wsd_pkg::PH_EXT64: begin
            remaining_in = {remaining_ff[55:0], stream_byte};
            if (hcount_ff >= wsd_pkg::EXT64_LAST) begin
               finish_len = 1'b1;
            end else begin
               hcount_in = hcount_ff + 3'd1;
            end
         end
         wsd_pkg::PH_MASK: begin
            key_in = {key_ff[23:0], stream_byte};
            if (hcount_ff >= wsd_pkg::MASK_LAST) begin
               hcount_in  = 3'd0;
               finish_hdr = 1'b1;
            end else begin
               hcount_in = hcount_ff + 3'd1;
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            pos_in       = pos_ff + 2'd1;
            remaining_in = rem_dec;
            if (last) begin
               phase_in = wsd_pkg::PH_HDR0;
            end
            if (opcode_ff == wsd_pkg::OP_BINARY) begin
               result.emit         = 1'b1;
               result.has_byte     = 1'b1;
               result.payload_byte = stream_byte ^ key_byte;
               result.frame_end    = last;
               result.frame_status = wsd_pkg::ST_BINARY;
            end else if (last) begin
               result.emit         = 1'b1;
               result.frame_end    = 1'b1;
               result.frame_status = wsd_pkg::status_of(opcode_ff);
            end
         end
         default: begin
            // first header byte, also any unused phase code
            opcode_in    = stream_byte[3:0];
            mask_in      = 1'b0;
            key_in       = 32'd0;
            pos_in       = 2'd0;
            hcount_in    = 3'd0;
            remaining_in = 64'd0;
            phase_in     = wsd_pkg::PH_HDR1;
         end
      endcase

      // length known: gather the key if masked
      if (finish_len) begin
         hcount_in = 3'd0;
         if (mask_in) begin
            phase_in = wsd_pkg::PH_MASK;
         end else begin
            finish_hdr = 1'b1;
         end
      end

      // header complete: empty frame ends here
      if (finish_hdr) begin
         if (remaining_in == 64'd0) begin
            phase_in            = wsd_pkg::PH_HDR0;
            result.emit         = 1'b1;
            result.frame_end    = 1'b1;
            result.frame_status = wsd_pkg::status_of(opcode_ff);
         end else begin
            phase_in = wsd_pkg::PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wsd_pkg::PH_HDR0;
         opcode_ff    <= 4'd0;
         mask_ff      <= 1'b0;
         remaining_ff <= 64'd0;
         hcount_ff    <= 3'd0;
         key_ff       <= 32'd0;
         pos_ff       <= 2'd0;
      end else if (take) begin
         phase_ff     <= phase_in;
         opcode_ff    <= opcode_in;
         mask_ff      <= mask_in;
         remaining_ff <= remaining_in;
         hcount_ff    <= hcount_in;
         key_ff       <= key_in;
         pos_ff       <= pos_in;
      end
   end

endmodule

FILE: sv/wsd_checker.sv
module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       has_byte,
   input logic [7:0] payload_byte,
   input logic       frame_end,
   input logic [1:0] frame_status
);

   // a pending result holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_byte)
         && $stable(has_byte) && $stable(frame_end) && $stable(frame_status))
      else $error("stalled result changed");

   // a new result follows an accepted byte
   a_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without accepted byte");

   a_nobyte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_byte |-> payload_byte == 8'd0)
      else $error("payload byte set without has_byte");

   a_noend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_end |-> frame_status == wsd_pkg::ST_BINARY)
      else $error("status set without frame end");

   a_binend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && has_byte && frame_end |-> frame_status == wsd_pkg::ST_BINARY)
      else $error("binary byte with non-binary status");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .has_byte     (rsp_chan.has_byte),
   .payload_byte (rsp_chan.payload_byte),
   .frame_end    (rsp_chan.frame_end),
   .frame_status (rsp_chan.frame_status)
);

FILE: dv/testbench.sv
module testbench;

   // header flag nibbles (fin, rsv1..rsv3)
   localparam logic [3:0] FLAGS_FIN  = 4'h8;
   localparam logic [3:0] FLAGS_NONE = 4'h0;
   localparam logic [3:0] FLAGS_RSV  = 4'h7;
   localparam logic [3:0] FLAGS_ALL  = 4'hF;

   // opcodes that only show up as rejected frames
   localparam logic [3:0] OP_CONT = 4'h0;

   localparam int RANDOM_BYTES  = 1000;
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   // how the payload length is encoded in the header
   typedef enum logic [1:0] {LEN_SHORT, LEN_WORD, LEN_LONG} len_form_type;

   // idling schedule, one quarter of the stream each
   typedef enum logic [1:0] {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] payload_byte;
      logic       frame_end;
      logic [1:0] frame_status;
   } deframed_type;

   logic clock;
   logic reset;

   wsd_req_if req_chan();
   wsd_rsp_if rsp_chan();

   websocket_frame_deframer_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // framed byte stream still to be offered, and results owed by the block
   logic [7:0]   stream_bytes[$];
   deframed_type expected_results[$];

   int total_bytes;
   int issued_bytes;
   int accepted_bytes;
   int mismatches;
   int cycle_count;

   deframed_type seen_result;
   deframed_type wanted_result;

   // parser state as the block should hold it
   logic [2:0]  parse_phase     = wsd_pkg::PH_HDR0;
   logic [3:0]  frame_opcode    = 4'h0;
   logic        frame_masked    = 1'b0;
   logic [63:0] bytes_left      = 64'd0;
   logic [2:0]  header_count    = 3'd0;
   logic [31:0] frame_key       = 32'd0;
   logic [1:0]  key_index       = 2'd0;

   // status that a finished frame reports for its opcode
   function automatic logic [1:0] frame_kind(input logic [3:0] op);
      if (op == wsd_pkg::OP_BINARY) return wsd_pkg::ST_BINARY;
      if (op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_PING) return wsd_pkg::ST_IGNORED;
      if (op == wsd_pkg::OP_CLOSE) return wsd_pkg::ST_CLOSE;
      return wsd_pkg::ST_REJECT;
   endfunction

   task automatic owe_result(input logic has, input logic [7:0] data, input logic last,
                             input logic [1:0] status);
      deframed_type r;
      r = '{has, data, last, status};
      expected_results.push_back(r);
   endtask

   // length and key both known: a zero-length frame ends right here
   task automatic header_known();
      if (bytes_left == 64'd0) begin
         parse_phase = wsd_pkg::PH_HDR0;
         owe_result(1'b0, 8'h00, 1'b1, frame_kind(frame_opcode));
      end else begin
         parse_phase = wsd_pkg::PH_PAYLOAD;
      end
   endtask

   // length known: a masked frame still carries its key
   task automatic length_known();
      header_count = 3'd0;
      if (frame_masked) parse_phase = wsd_pkg::PH_MASK;
      else header_known();
   endtask

   // advance the parser by one accepted byte
   task automatic parse_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      logic [7:0] plain;
      logic       last;
      case (parse_phase)
         wsd_pkg::PH_HDR1: begin
            frame_masked = b[7];
            header_count = 3'd0;
            bytes_left   = 64'd0;
            if (b[6:0] == wsd_pkg::LEN_EXT16) parse_phase = wsd_pkg::PH_EXT16;
            else if (b[6:0] == wsd_pkg::LEN_EXT64) parse_phase = wsd_pkg::PH_EXT64;
            else begin
               bytes_left = {57'd0, b[6:0]};
               length_known();
            end
         end
         wsd_pkg::PH_EXT16: begin
            bytes_left = {48'd0, bytes_left[7:0], b};
            if (header_count >= wsd_pkg::EXT16_LAST) length_known();
            else header_count++;
         end
         wsd_pkg::PH_EXT64: begin
            bytes_left = {bytes_left[55:0], b};
            if (header_count >= wsd_pkg::EXT64_LAST) length_known();
            else header_count++;
         end
         wsd_pkg::PH_MASK: begin
            frame_key = {frame_key[23:0], b};
            if (header_count >= wsd_pkg::MASK_LAST) begin
               header_count = 3'd0;
               header_known();
            end else begin
               header_count++;
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            // key bytes are used from the first received one on, cycling
            key_byte   = frame_masked ? frame_key[8*(3-key_index) +: 8] : 8'h00;
            plain      = b ^ key_byte;
            key_index  = key_index + 2'd1;
            bytes_left = bytes_left - 64'd1;
            last       = (bytes_left == 64'd0);
            if (last) parse_phase = wsd_pkg::PH_HDR0;
            if (frame_opcode == wsd_pkg::OP_BINARY)
               owe_result(1'b1, plain, last, wsd_pkg::ST_BINARY);
            else if (last) owe_result(1'b0, 8'h00, 1'b1, frame_kind(frame_opcode));
         end
         default: begin
            // first header byte; fin and rsv bits are don't-care
            frame_opcode = b[3:0];
            frame_masked = 1'b0;
            frame_key    = 32'd0;
            key_index    = 2'd0;
            header_count = 3'd0;
            bytes_left   = 64'd0;
            parse_phase  = wsd_pkg::PH_HDR1;
         end
      endcase
   endtask

   // append one frame; payload_count may be short of the length for a frame
   // that is never meant to finish
   task automatic queue_frame(input logic [3:0] flags, input logic [3:0] op,
                              input logic masked, input len_form_type form,
                              input logic [63:0] len, input int payload_count);
      stream_bytes.push_back({flags, op});
      case (form)
         LEN_SHORT: stream_bytes.push_back({masked, len[6:0]});
         LEN_WORD: begin
            stream_bytes.push_back({masked, wsd_pkg::LEN_EXT16});
            stream_bytes.push_back(len[15:8]);
            stream_bytes.push_back(len[7:0]);
         end
         default: begin
            stream_bytes.push_back({masked, wsd_pkg::LEN_EXT64});
            for (int i = 7; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
         end
      endcase
      if (masked) repeat (4) stream_bytes.push_back(8'($urandom));
      repeat (payload_count) stream_bytes.push_back(8'($urandom));
   endtask

   // idling follows the position in the stream
   function automatic idle_mode_type idle_mode();
      return idle_mode_type'((issued_bytes * 4) / total_bytes);
   endfunction

   task automatic note_mismatch(input string what, input deframed_type wanted,
                                input deframed_type seen);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display({"%s: expected has=%0b byte=%02h end=%0b status=%0d, ",
                   "got has=%0b byte=%02h end=%0b status=%0d"},
                  what, wanted.has_byte, wanted.payload_byte, wanted.frame_end,
                  wanted.frame_status, seen.has_byte, seen.payload_byte, seen.frame_end,
                  seen.frame_status);
   endtask

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // byte driver: offers the next byte once the current one is taken, and
   // runs the parser on every byte the block accepts
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.stream_byte <= 8'h00;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            parse_byte(req_chan.stream_byte);
            accepted_bytes++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (stream_bytes.size() > 0 &&
                !((idle_mode() == IDLE_SENDER && $urandom_range(0, 99) < 56) ||
                  (idle_mode() == IDLE_BOTH && $urandom_range(0, 99) < 24))) begin
               req_chan.valid       <= 1'b1;
               req_chan.stream_byte <= stream_bytes.pop_front();
               issued_bytes++;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: each item taken is held against the oldest one owed
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_result = '{rsp_chan.has_byte, rsp_chan.payload_byte, rsp_chan.frame_end,
                            rsp_chan.frame_status};
            if (expected_results.size() == 0) begin
               note_mismatch("unexpected result", '0, seen_result);
            end else begin
               wanted_result = expected_results.pop_front();
               if (seen_result.has_byte !== wanted_result.has_byte ||
                   seen_result.payload_byte !== wanted_result.payload_byte ||
                   seen_result.frame_end !== wanted_result.frame_end ||
                   seen_result.frame_status !== wanted_result.frame_status)
                  note_mismatch("result mismatch", wanted_result, seen_result);
            end
         end
         rsp_chan.ready <= !((idle_mode() == IDLE_RECEIVER && $urandom_range(0, 99) < 56) ||
                             (idle_mode() == IDLE_BOTH && $urandom_range(0, 99) < 24));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int           pick;
      logic [3:0]   op;
      len_form_type form;
      logic [63:0]  len;

      req_chan.valid       = 1'b0;
      req_chan.stream_byte = 8'h00;
      rsp_chan.ready       = 1'b0;
      reset                = 1'b1;
      issued_bytes         = 0;
      accepted_bytes       = 0;
      mismatches           = 0;
      cycle_count          = 0;

      // directed frames
      // empty binary frame ends on its second header byte
      queue_frame(FLAGS_FIN, wsd_pkg::OP_BINARY, 1'b0, LEN_SHORT, 64'd0, 0);
      // masked binary with fin clear, payload unmasked by the key
      queue_frame(FLAGS_NONE, wsd_pkg::OP_BINARY, 1'b1, LEN_SHORT, 64'd2, 2);
      // text payload swallowed, end item only
      queue_frame(FLAGS_FIN, wsd_pkg::OP_TEXT, 1'b0, LEN_SHORT, 64'd1, 1);
      // masked empty ping ends on the last key byte
      queue_frame(FLAGS_FIN, wsd_pkg::OP_PING, 1'b1, LEN_SHORT, 64'd0, 0);
      // close with a 16-bit length of zero
      queue_frame(FLAGS_FIN, wsd_pkg::OP_CLOSE, 1'b0, LEN_WORD, 64'd0, 0);
      // continuation is rejected, rsv bits set, 64-bit length
      queue_frame(FLAGS_RSV, OP_CONT, 1'b0, LEN_LONG, 64'd1, 1);

      // random frames, binary most often, with random flags and now and then any opcode
      while (stream_bytes.size() < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) op = wsd_pkg::OP_BINARY;
         else if (pick < 55) op = wsd_pkg::OP_TEXT;
         else if (pick < 65) op = wsd_pkg::OP_PING;
         else if (pick < 75) op = wsd_pkg::OP_CLOSE;
         else op = 4'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            form = LEN_SHORT;
            len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                               : 64'($urandom_range(0, 24));
         end else if (pick < 85) begin
            form = LEN_WORD;
            len  = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(256, 300))
                                               : 64'($urandom_range(0, 40));
         end else begin
            form = LEN_LONG;
            len  = 64'($urandom_range(0, 40));
         end
         queue_frame(4'($urandom), op, 1'($urandom), form, len, int'(len));
      end

      // all-ones 64-bit length: only the start of its payload is sent
      queue_frame(FLAGS_ALL, wsd_pkg::OP_BINARY, 1'b1, LEN_LONG, 64'hFFFF_FFFF_FFFF_FFFF, 16);

      total_bytes = stream_bytes.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // every byte taken, every owed item delivered, then a short drain
      while (accepted_bytes < total_bytes) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() > 0) mismatches += expected_results.size();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: websocket_frame_deframer_top.f
sv/wsd_pkg.sv
sv/wsd_ifs.sv
sv/wsd_parser.sv
sv/websocket_frame_deframer_top.sv
sv/wsd_checker.sv
dv/testbench.sv
